@@ design/uv_seam_vertex_splitter_macros.svh @@
// Assertion helpers used by the splitter design file.
`ifndef UV_SEAM_VERTEX_SPLITTER_MACROS_SVH
`define UV_SEAM_VERTEX_SPLITTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UVS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define UVS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/uvs_pkg.sv @@
package uvs_pkg;

  localparam int unsigned MaxBaseVerticesDef  = 4096;
  localparam int unsigned MaxTotalVerticesDef = 65536;

  // Field widths of the request and result items, the base register and the split count
  localparam int unsigned VidxW   = 12;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned OutIdxW = 16;
  localparam int unsigned BaseW   = 13;
  localparam int unsigned CountW  = 17;

  // Mesh generation tag kept next to each stored UV
  localparam int unsigned EpochW = 8;

  // Register map
  localparam int unsigned PaddrW = 3;
  localparam int unsigned PdataW = 32;
  localparam logic RegBaseVertexCount = 1'b0;  // paddr[2] of the only register

  typedef struct packed {
    logic [EpochW-1:0]   epoch;
    logic [2*CoordW-1:0] uv;
  } uvs_entry_t;

endpackage

@@ design/uvs_in_if.sv @@
interface uvs_in_if;
  import uvs_pkg::*;

  logic              valid;
  logic              ready;
  logic              new_mesh;
  logic [VidxW-1:0]  vertex_index;
  logic [CoordW-1:0] u_bits;
  logic [CoordW-1:0] v_bits;

  modport source (output valid, output new_mesh, output vertex_index, output u_bits,
                  output v_bits, input ready);
  modport sink (input valid, input new_mesh, input vertex_index, input u_bits,
                input v_bits, output ready);
endinterface

@@ design/uvs_out_if.sv @@
interface uvs_out_if;
  import uvs_pkg::*;

  logic               valid;
  logic               ready;
  logic [OutIdxW-1:0] out_index;
  logic               is_new_vertex;
  logic [VidxW-1:0]   copy_source;
  logic               index_error;
  logic               overflow;

  modport source (output valid, output out_index, output is_new_vertex, output copy_source,
                  output index_error, output overflow, input ready);
  modport sink (input valid, input out_index, input is_new_vertex, input copy_source,
                input index_error, input overflow, output ready);
endinterface

@@ design/uvs_uv_mem.sv @@
module uvs_uv_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  uvs_pkg::uvs_entry_t  wdata_i,
  input  logic                 re_i,
  input  logic [AddrW-1:0]     raddr_i,
  output uvs_pkg::uvs_entry_t  rdata_o
);
  import uvs_pkg::*;

  uvs_entry_t mem_q [Depth];
  uvs_entry_t rdata_q;

  // read-first: a same-address read returns the old entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/uv_seam_vertex_splitter.sv @@
// Channel   Direction  Payload                                              Handshake
// in_i      sink       new_mesh, vertex_index, u_bits, v_bits               valid/ready
// out_o     source     out_index, is_new_vertex, copy_source,               valid/ready
//                      index_error, overflow
// apb       slave      base_vertex_count at byte 0                          psel/penable
//
// One corner per cycle when the output is drained and no sweep runs: the UV table
// read is issued at accept, then compared and written back in the compare stage
// (two-stage read-modify-write on the single table RAM, forwarded from the last write).
// After reset a clearing pass writes all MAX_BASE_VERTICES entries, one per
// cycle, before the first request is taken. The same pass runs again when the
// 8-bit mesh tag wraps: on the 255th mesh restart after reset and on every
// 254th after that; the restarting corner is held until the pass ends.
// A stalled result holds the compare stage; the next request is still taken
// while the result register is full but the compare stage is free.
module uv_seam_vertex_splitter #(
  parameter int unsigned MAX_BASE_VERTICES  = uvs_pkg::MaxBaseVerticesDef,
  parameter int unsigned MAX_TOTAL_VERTICES = uvs_pkg::MaxTotalVerticesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [uvs_pkg::PaddrW-1:0]  paddr,
  input  logic [uvs_pkg::PdataW-1:0]  pwdata,
  output logic [uvs_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  uvs_in_if.sink                      in_i,
  uvs_out_if.source                   out_o
);
  import uvs_pkg::*;

  localparam int unsigned AddrW = (MAX_BASE_VERTICES > 1) ? $clog2(MAX_BASE_VERTICES) : 1;
  localparam int unsigned CandW = CountW + 1;
  localparam logic [EpochW-1:0] EpochMax = '1;
  localparam logic [EpochW-1:0] EpochFirst = EpochW'(1);
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [AddrW-1:0]  LastAddr = AddrW'(MAX_BASE_VERTICES - 1);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } uvs_state_e;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [BaseW-1:0] base_q;
  logic             cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegBaseVertexCount);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegBaseVertexCount) ? PdataW'(base_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_wr) begin
      base_q <= pwdata[BaseW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------
  uvs_state_e        state_q, state_d;
  logic [AddrW-1:0]  clr_idx_q;
  logic [EpochW-1:0] epoch_q;
  logic [CountW-1:0] count_q;

  // compare stage
  logic              s1_valid_q;
  logic              s1_cleared_q;  // table swept since this corner's read
  logic              s1_new_mesh_q;
  logic [VidxW-1:0]  s1_vi_q;
  logic [2*CoordW-1:0] s1_uv_q;

  // last table write, covers a read issued at the same edge
  logic              fwd_valid_q;
  logic [AddrW-1:0]  fwd_addr_q;
  uvs_entry_t        fwd_data_q;

  // result register
  logic               out_valid_q;
  logic [OutIdxW-1:0] out_index_q;
  logic               out_new_q;
  logic [VidxW-1:0]   out_src_q;
  logic               out_ierr_q;
  logic               out_ovf_q;

  logic accept, s1_done, wrap, clr_last;

  // ---------------------------------------------------------------------
  // Table RAM
  // ---------------------------------------------------------------------
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  uvs_entry_t       mem_wdata;
  uvs_entry_t       rd_entry;
  logic [AddrW-1:0] s1_addr;

  uvs_uv_mem #(
    .Depth (MAX_BASE_VERTICES),
    .AddrW (AddrW)
  ) u_uv_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (AddrW'(in_i.vertex_index)),
    .rdata_o (rd_entry)
  );

  // ---------------------------------------------------------------------
  // Compare stage
  // ---------------------------------------------------------------------
  logic [EpochW-1:0] eff_epoch;
  logic [CountW-1:0] eff_count;
  uvs_entry_t        cur_entry;
  logic              visited, in_range, no_room, first_visit, alloc;
  logic [CandW-1:0]  cand;
  logic [OutIdxW-1:0] res_index;
  logic [VidxW-1:0]  res_src;

  assign s1_addr   = AddrW'(s1_vi_q);
  assign eff_epoch = s1_new_mesh_q ? EpochW'(epoch_q + 1'b1) : epoch_q;
  assign eff_count = s1_new_mesh_q ? '0 : count_q;
  assign cur_entry = (fwd_valid_q && (fwd_addr_q == s1_addr)) ? fwd_data_q : rd_entry;
  assign visited   = !s1_cleared_q && (cur_entry.epoch == eff_epoch);
  assign in_range  = ({1'b0, s1_vi_q} < base_q) && (32'(s1_vi_q) < MAX_BASE_VERTICES);
  assign cand      = CandW'(base_q) + CandW'(eff_count);
  assign no_room   = (32'(cand) >= MAX_TOTAL_VERTICES) || (eff_count == CountMax);

  always_comb begin
    first_visit = 1'b0;
    alloc       = 1'b0;
    res_index   = OutIdxW'(s1_vi_q);
    res_src     = '0;
    if (in_range) begin
      if (!visited) begin
        first_visit = 1'b1;
      end else if (cur_entry.uv != s1_uv_q) begin
        if (!no_room) begin
          alloc     = 1'b1;
          res_index = cand[OutIdxW-1:0];
          res_src   = s1_vi_q;
        end
      end
    end
  end

  // a seam that could not be split
  logic res_ovf;
  assign res_ovf = in_range && visited && (cur_entry.uv != s1_uv_q) && no_room;

  // mesh tag wrap: the held corner waits for a full sweep
  assign wrap     = s1_valid_q && s1_new_mesh_q && (epoch_q == EpochMax);
  assign s1_done  = s1_valid_q && (state_q == ST_RUN) && !wrap &&
                    (!out_valid_q || out_o.ready);
  assign in_i.ready = (state_q == ST_RUN) && (!s1_valid_q || s1_done);
  assign accept   = in_i.valid && in_i.ready;
  assign clr_last = (clr_idx_q == LastAddr);

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_q;
      mem_wdata = '0;
    end else begin
      mem_we          = s1_done && first_visit;
      mem_waddr       = s1_addr;
      mem_wdata.epoch = eff_epoch;
      mem_wdata.uv    = s1_uv_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_RUN;
      ST_RUN:   if (wrap) state_d = ST_CLEAR;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_idx_q    <= '0;
      epoch_q      <= '0;
      count_q      <= '0;
      s1_valid_q   <= 1'b0;
      s1_cleared_q <= 1'b0;
      fwd_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == ST_CLEAR) begin
        clr_idx_q   <= clr_last ? '0 : AddrW'(clr_idx_q + 1'b1);
        fwd_valid_q <= 1'b0;
        if (clr_last) begin
          epoch_q <= EpochFirst;  // tag zero now marks every entry unvisited
        end
      end else if (wrap) begin
        clr_idx_q    <= '0;
        s1_cleared_q <= 1'b1;
      end

      if (s1_done) begin
        epoch_q <= eff_epoch;
        count_q <= alloc ? CountW'(eff_count + 1'b1) : eff_count;
        if (first_visit) begin
          fwd_valid_q <= 1'b1;
        end
      end

      if (accept) begin
        s1_valid_q   <= 1'b1;
        s1_cleared_q <= 1'b0;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_done) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_new_mesh_q <= in_i.new_mesh;
      s1_vi_q       <= in_i.vertex_index;
      s1_uv_q       <= {in_i.u_bits, in_i.v_bits};
    end
    if (mem_we && (state_q == ST_RUN)) begin
      fwd_addr_q <= mem_waddr;
      fwd_data_q <= mem_wdata;
    end
    if (s1_done) begin
      out_index_q <= res_index;
      out_new_q   <= alloc;
      out_src_q   <= res_src;
      out_ierr_q  <= !in_range;
      out_ovf_q   <= res_ovf;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_index     = out_index_q;
  assign out_o.is_new_vertex = out_new_q;
  assign out_o.copy_source   = out_src_q;
  assign out_o.index_error   = out_ierr_q;
  assign out_o.overflow      = out_ovf_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
`include "uv_seam_vertex_splitter_macros.svh"

  `UVS_ASSERT_NOW(a_no_req_in_clear, clk_i, rst_ni, state_q == ST_CLEAR, !in_i.ready, "request taken during table sweep")
  `UVS_ASSERT_NOW(a_live_epoch_nonzero, clk_i, rst_ni, state_q == ST_RUN, epoch_q != '0, "live mesh tag collides with swept tag")
  `UVS_ASSERT_NOW(a_no_result_overwrite, clk_i, rst_ni, s1_done, !out_valid_q || out_o.ready, "result register overwritten")
  `UVS_ASSERT_NOW(a_flags_exclusive, clk_i, rst_ni, out_valid_q, !(out_new_q && (out_ovf_q || out_ierr_q)), "split flagged together with an error")
  `UVS_ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni, accept, s1_valid_q, "accepted request lost before compare")

endmodule
